FILE: hdl/packed_nibble_framebuffer_engine_macros.svh
// assertion helpers for the framebuffer engine
`ifndef PACKED_NIBBLE_FRAMEBUFFER_ENGINE_MACROS_SVH
`define PACKED_NIBBLE_FRAMEBUFFER_ENGINE_MACROS_SVH

// clocked check, muted while in reset
`define PNFB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that also holds during reset
`define PNFB_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/pnfb_pkg.sv
// ----------------------------------------------------------------------------
// pnfb_pkg
// Shared constants, types and command codes of the framebuffer engine.
// ----------------------------------------------------------------------------
package pnfb_pkg;

  localparam int FB_BYTES       = 262144;
  localparam int FB_AW          = $clog2(FB_BYTES);
  localparam int MAX_LINE_BYTES = 512;
  localparam int LEN_W          = 10;
  localparam int CRD_W          = 10;
  localparam int PCRD_W         = 12;
  localparam int SIZE_W         = 11;
  localparam int PIX_W          = 4;
  localparam int KIND_W         = 3;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DAT_W      = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_LINE_BYTES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DRAW_MODE  = 1'd1;

  typedef enum logic [KIND_W-1:0] {
    K_WRITE = 3'd0,
    K_READ  = 3'd1,
    K_HSPAN = 3'd2,
    K_VSPAN = 3'd3,
    K_COPY  = 3'd4
  } kind_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SADDR,
    S_SRD,
    S_DADDR,
    S_DRD,
    S_DWR,
    S_OUT
  } state_t;

  // pixel coordinate handed to the address unit
  typedef struct packed {
    logic              load;
    logic [PCRD_W-1:0] x;
    logic [PCRD_W-1:0] y;
    logic [LEN_W-1:0]  len;
  } agen_req_t;

  typedef struct packed {
    logic [FB_AW-1:0] addr;
    logic             hi;
  } agen_rsp_t;

endpackage

FILE: hdl/pnfb_if.sv
// ----------------------------------------------------------------------------
// pnfb_cmd_if / pnfb_pix_if
// Valid/ready channels for command words and pixel result words.
// ----------------------------------------------------------------------------
interface pnfb_cmd_if import pnfb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [CRD_W-1:0]  x_coord;
  logic [CRD_W-1:0]  y_coord;
  logic [CRD_W-1:0]  end_coord;
  logic [PIX_W-1:0]  color;
  logic [CRD_W-1:0]  src_x;
  logic [CRD_W-1:0]  src_y;
  logic [SIZE_W-1:0] width;
  logic [SIZE_W-1:0] height;

  modport source (output valid, kind, x_coord, y_coord, end_coord, color,
                  src_x, src_y, width, height, input ready);
  modport sink   (input valid, kind, x_coord, y_coord, end_coord, color,
                  src_x, src_y, width, height, output ready);
endinterface

interface pnfb_pix_if import pnfb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;

  modport source (output valid, pixel, input ready);
  modport sink   (input valid, pixel, output ready);
endinterface

FILE: hdl/pnfb_ram.sv
// ----------------------------------------------------------------------------
// pnfb_ram
// Single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module pnfb_ram #(
  parameter int AW = 18,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic          re,
  input  logic [AW-1:0] addr,
  input  logic [DW-1:0] wdata,
  output logic [DW-1:0] rdata
);
  logic [DW-1:0] mem [0:(1<<AW)-1];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;
endmodule

FILE: hdl/pnfb_agen.sv
// ----------------------------------------------------------------------------
// pnfb_agen
// Registered byte address unit: y * line length + x / 2, wrapped to the store.
// ----------------------------------------------------------------------------
module pnfb_agen import pnfb_pkg::*; (
  input  logic      clk,
  input  agen_req_t req,
  output agen_rsp_t rsp
);
  logic [PCRD_W+LEN_W-1:0] prod;
  logic [PCRD_W+LEN_W-1:0] sum;
  agen_rsp_t               rsp_r;

  assign prod = PCRD_W'(req.y) * LEN_W'(req.len);
  assign sum  = prod + (PCRD_W+LEN_W)'(req.x[PCRD_W-1:1]);

  always_ff @(posedge clk) begin
    if (req.load) begin
      rsp_r.addr <= sum[FB_AW-1:0];
      rsp_r.hi   <= ~req.x[0];
    end
  end

  assign rsp = rsp_r;
endmodule

FILE: hdl/packed_nibble_framebuffer_engine.sv
// ----------------------------------------------------------------------------
// packed_nibble_framebuffer_engine
// 4-bit packed framebuffer with pixel, span and rectangle copy commands.
// ----------------------------------------------------------------------------
// After reset the block zeroes its 262144-byte store, one byte per cycle, and
// takes no command word while it clears. Each pixel written is a
// read-modify-write on the single store port: a write or span pixel steps
// through address multiply, read and write, a read through address multiply,
// read and result, and a copied pixel has source address and source read
// ahead of those. Commands run one at a time. A read result sits in an
// output register, and the next command is taken while it waits.
module packed_nibble_framebuffer_engine import pnfb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  pnfb_cmd_if.sink             in_cmd,
  pnfb_pix_if.source           out_pix,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);
`include "packed_nibble_framebuffer_engine_macros.svh"

  state_t state_r, state_nxt;

  logic [LEN_W-1:0]  line_bytes_r;
  logic              draw_mode_r;
  logic [LEN_W-1:0]  len_r;
  logic [KIND_W-1:0] kind_r;
  logic [PCRD_W-1:0] dx_r, dy_r, sx_r, sy_r;
  logic [PCRD_W-1:0] dx_nxt, dy_nxt, sx_nxt, sy_nxt;
  logic [SIZE_W-1:0] ci_r, cj_r, ci_nxt, cj_nxt;
  logic [CRD_W-1:0]  end_r;
  logic [PIX_W-1:0]  color_r, color_nxt;
  logic [SIZE_W-1:0] w_r, h_r;
  logic [FB_AW-1:0]  clr_r;
  logic              out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0]  out_pixel_r, out_pixel_nxt;

  agen_req_t        areq;
  agen_rsp_t        arsp;
  logic             ram_we, ram_re;
  logic [FB_AW-1:0] ram_addr;
  logic [7:0]       ram_wdata, ram_rdata;
  logic [PIX_W-1:0] rd_nib;
  logic             accept;
  logic             last;

  pnfb_agen u_agen (.clk(clk), .req(areq), .rsp(arsp));

  pnfb_ram #(.AW(FB_AW), .DW(8)) u_ram (
    .clk(clk), .we(ram_we), .re(ram_re), .addr(ram_addr),
    .wdata(ram_wdata), .rdata(ram_rdata)
  );

  assign accept = in_cmd.valid && in_cmd.ready;
  assign rd_nib = arsp.hi ? ram_rdata[7:4] : ram_rdata[3:0];

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_bytes_r <= LEN_W'(320);
      draw_mode_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LINE_BYTES: line_bytes_r <= cfg_data[LEN_W-1:0];
        CFG_DRAW_MODE:  draw_mode_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (state_r == S_CLEAR) begin
        clr_r <= clr_r + FB_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    dx_r        <= dx_nxt;
    dy_r        <= dy_nxt;
    sx_r        <= sx_nxt;
    sy_r        <= sy_nxt;
    ci_r        <= ci_nxt;
    cj_r        <= cj_nxt;
    color_r     <= color_nxt;
    out_pixel_r <= out_pixel_nxt;
    if (accept) begin
      kind_r <= in_cmd.kind;
      end_r  <= in_cmd.end_coord;
      w_r    <= in_cmd.width;
      h_r    <= in_cmd.height;
      len_r  <= (line_bytes_r > LEN_W'(MAX_LINE_BYTES)) ? LEN_W'(MAX_LINE_BYTES)
                                                          : line_bytes_r;
    end
  end

  always_comb begin
    case (kind_r)
      K_HSPAN: last = (dx_r[CRD_W-1:0] == end_r);
      K_VSPAN: last = (dy_r[CRD_W-1:0] == end_r);
      K_COPY:  last = (ci_r == w_r - SIZE_W'(1)) && (cj_r == h_r - SIZE_W'(1));
      default: last = 1'b1;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    sx_nxt        = sx_r;
    sy_nxt        = sy_r;
    ci_nxt        = ci_r;
    cj_nxt        = cj_r;
    color_nxt     = color_r;
    out_valid_nxt = out_valid_r && !out_pix.ready;
    out_pixel_nxt = out_pixel_r;
    in_cmd.ready  = 1'b0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_addr      = arsp.addr;
    ram_wdata     = '0;
    areq.load     = 1'b0;
    areq.x        = dx_r;
    areq.y        = dy_r;
    areq.len      = len_r;

    case (state_r)
      S_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = clr_r;
        if (clr_r == {FB_AW{1'b1}}) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_cmd.ready = 1'b1;
        if (in_cmd.valid) begin
          dx_nxt    = PCRD_W'(in_cmd.x_coord);
          dy_nxt    = PCRD_W'(in_cmd.y_coord);
          sx_nxt    = PCRD_W'(in_cmd.src_x);
          sy_nxt    = PCRD_W'(in_cmd.src_y);
          ci_nxt    = '0;
          cj_nxt    = '0;
          color_nxt = in_cmd.color;
          case (in_cmd.kind)
            K_WRITE, K_READ: state_nxt = S_DADDR;
            K_HSPAN: begin
              if (in_cmd.end_coord >= in_cmd.x_coord) state_nxt = S_DADDR;
            end
            K_VSPAN: begin
              if (in_cmd.end_coord >= in_cmd.y_coord) state_nxt = S_DADDR;
            end
            K_COPY: begin
              if (in_cmd.width != '0 && in_cmd.height != '0) state_nxt = S_SADDR;
            end
            default: ;
          endcase
        end
      end
      S_SADDR: begin
        areq.load = 1'b1;
        areq.x    = sx_r;
        areq.y    = sy_r;
        state_nxt = S_SRD;
      end
      S_SRD: begin
        ram_re    = 1'b1;
        state_nxt = S_DADDR;
      end
      S_DADDR: begin
        // source byte arrives here for a copy
        if (kind_r == K_COPY) begin
          color_nxt = rd_nib;
        end
        areq.load = 1'b1;
        state_nxt = S_DRD;
      end
      S_DRD: begin
        ram_re    = 1'b1;
        state_nxt = (kind_r == K_READ) ? S_OUT : S_DWR;
      end
      S_DWR: begin
        ram_we = 1'b1;
        if (draw_mode_r && kind_r != K_COPY) begin
          ram_wdata = arsp.hi ? (ram_rdata ^ {color_r, 4'h0})
                              : (ram_rdata ^ {4'h0, color_r});
        end else begin
          ram_wdata = arsp.hi ? {color_r, ram_rdata[3:0]}
                              : {ram_rdata[7:4], color_r};
        end
        if (last) begin
          state_nxt = S_IDLE;
        end else begin
          case (kind_r)
            K_HSPAN: begin
              dx_nxt    = dx_r + PCRD_W'(1);
              state_nxt = S_DADDR;
            end
            K_VSPAN: begin
              dy_nxt    = dy_r + PCRD_W'(1);
              state_nxt = S_DADDR;
            end
            default: begin
              // copy walks a row left to right, then steps down a line
              if (ci_r == w_r - SIZE_W'(1)) begin
                ci_nxt = '0;
                cj_nxt = cj_r + SIZE_W'(1);
                dx_nxt = dx_r - PCRD_W'(ci_r);
                sx_nxt = sx_r - PCRD_W'(ci_r);
                dy_nxt = dy_r + PCRD_W'(1);
                sy_nxt = sy_r + PCRD_W'(1);
              end else begin
                ci_nxt = ci_r + SIZE_W'(1);
                dx_nxt = dx_r + PCRD_W'(1);
                sx_nxt = sx_r + PCRD_W'(1);
              end
              state_nxt = S_SADDR;
            end
          endcase
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_pix.ready) begin
          out_valid_nxt = 1'b1;
          out_pixel_nxt = rd_nib;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_pix.valid = out_valid_r;
  assign out_pix.pixel = out_pixel_r;

  `PNFB_ASSERT(a_we_states, ram_we |-> (state_r == S_CLEAR || state_r == S_DWR), "store write outside write step")
  `PNFB_ASSERT(a_ready_idle, in_cmd.ready |-> (state_r == S_IDLE), "command taken while busy")
  `PNFB_ASSERT(a_read_result, (state_r == S_DRD && kind_r == K_READ) |=> (state_r == S_OUT), "pixel read lost its result")
  `PNFB_ASSERT(a_re_we_excl, !(ram_re && ram_we), "store read and write in one cycle")
endmodule
